// ===== rtl/mcr_pkg.sv =====
// Shared constants, register codes and structure types for the midpoint circle rasterizer.
// Used by mcr_point, midpoint_circle_rasterizer and its checker; depends on nothing.
package mcr_pkg;

  localparam int unsigned MaxDim   = 4096;
  localparam int unsigned DimW     = 13;
  localparam int unsigned PosW     = $clog2(MaxDim);
  localparam int unsigned CoordW   = 14;
  localparam int unsigned RadW     = 11;
  localparam int unsigned PixW     = 15;
  localparam int unsigned AddrW    = 26;
  localparam int unsigned ColorW   = 32;
  localparam int unsigned DecW     = 16;
  localparam int unsigned BppW     = 3;
  localparam int unsigned StrideW  = 15;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned PtIdxW   = 3;

  localparam logic [CfgIdxW-1:0] CfgImageWidth   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBytesPerPix  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgRowStride    = 2'd3;

  localparam logic CmdStart = 1'b0;
  localparam logic CmdStep  = 1'b1;

  localparam logic [DimW-1:0]    RstImageWidth  = 13'd640;
  localparam logic [DimW-1:0]    RstImageHeight = 13'd480;
  localparam logic [BppW-1:0]    RstBytesPerPix = 3'd3;
  localparam logic [StrideW-1:0] RstRowStride   = 15'd1920;

  localparam logic [PtIdxW-1:0]  LastPoint      = 3'd7;

  typedef struct packed {
    logic [DimW-1:0]    width;
    logic [DimW-1:0]    height;
    logic [BppW-1:0]    bpp;
    logic [StrideW-1:0] stride;
  } geom_t;

  // Snapshot of one step: the offsets before the walk advances.
  typedef struct packed {
    logic [CoordW-1:0] ctr_x;
    logic [CoordW-1:0] ctr_y;
    logic [RadW-1:0]   off_a;
    logic [RadW-1:0]   off_b;
    logic [ColorW-1:0] color;
    logic              fin;
  } job_t;

  typedef struct packed {
    logic [PixW-1:0]   pix_x;
    logic [PixW-1:0]   pix_y;
    logic              in_bounds;
    logic [AddrW-1:0]  byte_addr;
    logic [ColorW-1:0] color_out;
    logic              last;
  } point_t;

endpackage

// ===== rtl/midpoint_circle_rasterizer.sv =====
// Top level of the midpoint circle rasterizer: walk state, step register and output word.
// Depends on mcr_pkg and mcr_point.
//
// Usage
//   Input channel (in_valid_i / in_stall_o): a start word (cmd 0) latches the
//   centre, radius and colour and emits nothing; a step word (cmd 1) advances
//   the walk one column and yields eight point words on the output channel
//   (out_valid_o / out_stall_i). A step word while no circle is active is
//   taken and dropped. The eighth point of the final step carries last_o.
//   Configuration: write image width, height, bytes per pixel and row stride
//   through cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
// Flow
//   A step word is taken into the step register at the edge it is accepted;
//   its first point moves on to the output register once that one is free or
//   draining, and the remaining seven follow one per cycle while the output is
//   not stalled, from the single point generator that feeds the output
//   register. The next word is accepted in the same cycle the eighth point is
//   loaded, so unstalled steps stream one point per cycle with no bubble.
// Reset
//   rst_ni clears the walk, the step valid flag, the point counter and the output valid, and loads
//   the default geometry (640 x 480, 3 bytes per pixel, stride 1920).
// Stall
//   A stalled output holds its word; the step register then holds too, and
//   the input stalls until the last point of the pending step enters the output.
module midpoint_circle_rasterizer
  import mcr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  input  logic [CoordW-1:0]   center_x_i,
  input  logic [CoordW-1:0]   center_y_i,
  input  logic [RadW-1:0]     radius_i,
  input  logic [ColorW-1:0]   color_i,
  // point words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PixW-1:0]     pix_x_o,
  output logic [PixW-1:0]     pix_y_o,
  output logic                in_bounds_o,
  output logic [AddrW-1:0]    byte_addr_o,
  output logic [ColorW-1:0]   color_out_o,
  output logic                last_o
);

  // Geometry registers
  geom_t geom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.width  <= RstImageWidth;
      geom_q.height <= RstImageHeight;
      geom_q.bpp    <= RstBytesPerPix;
      geom_q.stride <= RstRowStride;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgImageWidth:  geom_q.width  <= cfg_data_i[DimW-1:0];
        CfgImageHeight: geom_q.height <= cfg_data_i[DimW-1:0];
        CfgBytesPerPix: geom_q.bpp    <= cfg_data_i[BppW-1:0];
        CfgRowStride:   geom_q.stride <= cfg_data_i[StrideW-1:0];
        default: ;
      endcase
    end
  end

  // Walk state
  logic                     active_q, active_d;
  logic [CoordW-1:0]        ctr_x_q, ctr_x_d, ctr_y_q, ctr_y_d;
  logic [RadW-1:0]          off_a_q, off_a_d, off_b_q, off_b_d;
  logic signed [DecW-1:0]   dec_q, dec_d;
  logic [ColorW-1:0]        color_q, color_d;

  // Step register and point counter
  logic                     job_vld_q, job_vld_d;
  job_t                     job_q, job_d;
  logic [PtIdxW-1:0]        idx_q, idx_d;

  // Output register
  logic                     out_vld_q, out_vld_d;
  point_t                   out_q, out_d;
  point_t                   point;

  logic in_acc, adv, job_done, take_step;
  logic signed [DecW-1:0] a_ext, b_ext;
  logic [RadW-1:0]        a_nxt, b_nxt;
  logic                   fin;

  // Advance the generator while a step is pending and the output register is free or draining.
  assign adv        = job_vld_q && (!out_vld_q || !out_stall_i);
  assign job_done   = adv && (idx_q == LastPoint);
  assign in_stall_o = job_vld_q && !job_done;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign take_step  = in_acc && (cmd_i == CmdStep) && active_q;

  assign a_ext = DecW'(off_a_q);
  assign b_ext = DecW'(off_b_q);

  // One column of the midpoint walk, or the start of a new walk.
  always_comb begin
    active_d = active_q;
    ctr_x_d  = ctr_x_q;
    ctr_y_d  = ctr_y_q;
    off_a_d  = off_a_q;
    off_b_d  = off_b_q;
    dec_d    = dec_q;
    color_d  = color_q;
    a_nxt    = off_a_q + RadW'(1);
    b_nxt    = off_b_q;
    fin      = 1'b1;
    if (off_a_q < off_b_q) begin
      if (dec_q < 0) begin
        b_nxt = off_b_q;
        dec_d = dec_q + (a_ext <<< 2) + DecW'(6);
      end else begin
        b_nxt = off_b_q - RadW'(1);
        dec_d = dec_q + ((a_ext - b_ext) <<< 2) + DecW'(10);
      end
      fin = a_nxt > b_nxt;
    end
    if (in_acc) begin
      if (cmd_i == CmdStart) begin
        active_d = 1'b1;
        ctr_x_d  = center_x_i;
        ctr_y_d  = center_y_i;
        off_a_d  = '0;
        off_b_d  = radius_i;
        dec_d    = DecW'(3) - (DecW'(radius_i) <<< 1);
        color_d  = color_i;
      end else if (active_q) begin
        if (off_a_q < off_b_q) begin
          off_a_d = a_nxt;
          off_b_d = b_nxt;
        end else begin
          dec_d = dec_q;
        end
        active_d = !fin;
      end else begin
        dec_d = dec_q;
      end
    end else begin
      dec_d = dec_q;
    end
  end

  // Snapshot the pre-advance offsets for the point generator and count its points.
  always_comb begin
    job_d       = job_q;
    job_vld_d   = job_vld_q;
    idx_d       = idx_q;
    if (adv) begin
      idx_d = idx_q + PtIdxW'(1);
      if (job_done) job_vld_d = 1'b0;
    end
    if (take_step) begin
      job_vld_d   = 1'b1;
      idx_d       = '0;
      job_d.ctr_x = ctr_x_q;
      job_d.ctr_y = ctr_y_q;
      job_d.off_a = off_a_q;
      job_d.off_b = off_b_q;
      job_d.color = color_q;
      job_d.fin   = fin;
    end
  end

  mcr_point u_point (
    .job_i   (job_q),
    .idx_i   (idx_q),
    .geom_i  (geom_q),
    .point_o (point)
  );

  // Load a new point when advancing; drop the old word once taken.
  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (adv) begin
      out_d     = point;
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      ctr_x_q   <= '0;
      ctr_y_q   <= '0;
      off_a_q   <= '0;
      off_b_q   <= '0;
      dec_q     <= '0;
      color_q   <= '0;
      job_vld_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      active_q  <= active_d;
      ctr_x_q   <= ctr_x_d;
      ctr_y_q   <= ctr_y_d;
      off_a_q   <= off_a_d;
      off_b_q   <= off_b_d;
      dec_q     <= dec_d;
      color_q   <= color_d;
      job_vld_q <= job_vld_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign pix_x_o     = out_q.pix_x;
  assign pix_y_o     = out_q.pix_y;
  assign in_bounds_o = out_q.in_bounds;
  assign byte_addr_o = out_q.byte_addr;
  assign color_out_o = out_q.color_out;
  assign last_o      = out_q.last;

endmodule

// ===== rtl/mcr_point.sv =====
// One symmetric point of a step: coordinates, bounds check and byte address.
// Depends on mcr_pkg.
module mcr_point
  import mcr_pkg::*;
(
  input  job_t              job_i,
  input  logic [PtIdxW-1:0] idx_i,
  input  geom_t             geom_i,
  output point_t            point_o
);

  logic [RadW-1:0]     mag_x, mag_y;
  logic [PixW-1:0]     base_x, base_y, ext_x, ext_y, x, y;
  logic [DimW-1:0]     w_lim, h_lim;
  logic                x_in, y_in, inb;
  logic [AddrW:0]      row_off;
  logic [PosW+BppW-1:0] col_off;
  logic [AddrW-1:0]    addr;

  // Bit 2 swaps the offsets, bit 0 negates x, bit 1 negates y.
  assign mag_x  = idx_i[2] ? job_i.off_b : job_i.off_a;
  assign mag_y  = idx_i[2] ? job_i.off_a : job_i.off_b;
  assign base_x = {job_i.ctr_x[CoordW-1], job_i.ctr_x};
  assign base_y = {job_i.ctr_y[CoordW-1], job_i.ctr_y};
  assign ext_x  = PixW'(mag_x);
  assign ext_y  = PixW'(mag_y);
  assign x      = idx_i[0] ? base_x - ext_x : base_x + ext_x;
  assign y      = idx_i[1] ? base_y - ext_y : base_y + ext_y;

  assign w_lim = (geom_i.width  > DimW'(MaxDim)) ? DimW'(MaxDim) : geom_i.width;
  assign h_lim = (geom_i.height > DimW'(MaxDim)) ? DimW'(MaxDim) : geom_i.height;
  assign x_in  = !x[PixW-1] && (x[PixW-2:0] < (PixW-1)'(w_lim));
  assign y_in  = !y[PixW-1] && (y[PixW-2:0] < (PixW-1)'(h_lim));
  assign inb   = x_in && y_in;

  // Inside the image both coordinates fit in PosW bits.
  assign row_off = (AddrW+1)'(y[PosW-1:0]) * (AddrW+1)'(geom_i.stride);
  assign col_off = (PosW+BppW)'(x[PosW-1:0]) * (PosW+BppW)'(geom_i.bpp);
  assign addr    = row_off[AddrW-1:0] + AddrW'(col_off);

  always_comb begin
    point_o.pix_x     = x;
    point_o.pix_y     = y;
    point_o.in_bounds = inb;
    point_o.byte_addr = inb ? addr : '0;
    point_o.color_out = job_i.color;
    point_o.last      = job_i.fin && (idx_i == LastPoint);
  end

endmodule

// ===== rtl/mcr_checker.sv =====
// Port-level checks for the midpoint circle rasterizer, bound to its top level.
// Depends on mcr_pkg and midpoint_circle_rasterizer.
module mcr_checker
  import mcr_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [PixW-1:0]   pix_x_o,
  input logic [PixW-1:0]   pix_y_o,
  input logic [AddrW-1:0]  byte_addr_o,
  input logic              last_o
);

  // Hold a stalled point word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pix_x_o) && $stable(pix_y_o)
      && $stable(byte_addr_o) && $stable(last_o))
    else $error("stalled point word changed");

  // Keep the input stalled while the pending output stays stuck.
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && out_valid_o && out_stall_i |=> !out_stall_i || in_stall_o)
    else $error("input released while output stalled");

  // No point word right after reset is released.
  a_rst_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("activity straight out of reset");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pix_x_o     (pix_x_o),
  .pix_y_o     (pix_y_o),
  .byte_addr_o (byte_addr_o),
  .last_o      (last_o)
);

// ===== tb/sv/circle_point_checker.sv =====
// Checker for the midpoint circle rasterizer: watches the configuration port and both
// word channels, predicts the point words of every step and compares them in order.
// Depends on mcr_pkg for widths, register codes and the point structure.
module circle_point_checker
  import mcr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                cmd_i,
  input  logic [CoordW-1:0]   center_x_i,
  input  logic [CoordW-1:0]   center_y_i,
  input  logic [RadW-1:0]     radius_i,
  input  logic [ColorW-1:0]   color_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [PixW-1:0]     pix_x_i,
  input  logic [PixW-1:0]     pix_y_i,
  input  logic                in_bounds_i,
  input  logic [AddrW-1:0]    byte_addr_i,
  input  logic [ColorW-1:0]   color_out_i,
  input  logic                last_i,
  output int unsigned         mismatches_o,
  output int unsigned         points_due_o,
  output int unsigned         points_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  geom_t                    geom;
  logic                     walking;
  logic signed [CoordW-1:0] org_x;
  logic signed [CoordW-1:0] org_y;
  logic [RadW-1:0]          col_off;
  logic [RadW-1:0]          row_off;
  int                       decision;
  logic [ColorW-1:0]        pen;
  point_t                   due_q[$];

  // Build one point word from absolute coordinates and the current geometry.
  function automatic point_t make_point(int x, int y, logic fin);
    int         w;
    int         h;
    logic [63:0] addr;
    point_t     p;
    w = (int'(geom.width) > int'(MaxDim)) ? int'(MaxDim) : int'(geom.width);
    h = (int'(geom.height) > int'(MaxDim)) ? int'(MaxDim) : int'(geom.height);
    p.pix_x     = x[PixW-1:0];
    p.pix_y     = y[PixW-1:0];
    p.in_bounds = (x >= 0) && (x < w) && (y >= 0) && (y < h);
    addr = '0;
    if (p.in_bounds) begin
      addr = 64'(y) * 64'(geom.stride) + 64'(x) * 64'(geom.bpp);
    end
    p.byte_addr = addr[AddrW-1:0];
    p.color_out = pen;
    p.last      = fin;
    return p;
  endfunction

  // Emit the eight points of the current offsets, then advance one column.
  task automatic advance_walk();
    int   a;
    int   b;
    int   cx;
    int   cy;
    logic fin;
    a  = int'(col_off);
    b  = int'(row_off);
    cx = int'(org_x);
    cy = int'(org_y);
    if (a >= b) begin
      fin = 1'b1;
    end else begin
      if (decision < 0) begin
        decision += 4 * a + 6;
      end else begin
        decision += 4 * (a - b) + 10;
        row_off = RadW'(b - 1);
      end
      col_off = RadW'(a + 1);
      fin = (col_off > row_off);
    end
    if (fin) walking = 1'b0;
    due_q.push_back(make_point(cx + a, cy + b, 1'b0));
    due_q.push_back(make_point(cx - a, cy + b, 1'b0));
    due_q.push_back(make_point(cx + a, cy - b, 1'b0));
    due_q.push_back(make_point(cx - a, cy - b, 1'b0));
    due_q.push_back(make_point(cx + b, cy + a, 1'b0));
    due_q.push_back(make_point(cx - b, cy + a, 1'b0));
    due_q.push_back(make_point(cx + b, cy - a, 1'b0));
    due_q.push_back(make_point(cx - b, cy - a, fin));
  endtask

  task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches_o++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    if (!rst_ni) begin
      geom             = '{RstImageWidth, RstImageHeight, RstBytesPerPix, RstRowStride};
      walking          = 1'b0;
      org_x            = '0;
      org_y            = '0;
      col_off          = '0;
      row_off          = '0;
      decision         = 0;
      pen              = '0;
      mismatches_o     = 0;
      points_checked_o = 0;
      due_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        points_checked_o++;
        if (due_q.size() == 0) begin
          mismatches_o++;
          $display("%0t: point word with none due, actual x 0x%0h y 0x%0h", $time,
                   pix_x_i, pix_y_i);
        end else begin
          want = due_q.pop_front();
          compare_field("pix_x", 64'(want.pix_x), 64'(pix_x_i));
          compare_field("pix_y", 64'(want.pix_y), 64'(pix_y_i));
          compare_field("in_bounds", 64'(want.in_bounds), 64'(in_bounds_i));
          compare_field("byte_addr", 64'(want.byte_addr), 64'(byte_addr_i));
          compare_field("color_out", 64'(want.color_out), 64'(color_out_i));
          compare_field("last", 64'(want.last), 64'(last_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgImageWidth:  geom.width  = cfg_data_i[DimW-1:0];
          CfgImageHeight: geom.height = cfg_data_i[DimW-1:0];
          CfgBytesPerPix: geom.bpp    = cfg_data_i[BppW-1:0];
          CfgRowStride:   geom.stride = cfg_data_i[StrideW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == CmdStart) begin
          org_x    = center_x_i;
          org_y    = center_y_i;
          col_off  = '0;
          row_off  = radius_i;
          decision = 3 - 2 * int'(radius_i);
          pen      = color_i;
          walking  = 1'b1;
        end else if (walking) begin
          advance_walk();
        end
      end
    end
    points_due_o = due_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the midpoint circle rasterizer testbench: clock, reset, word stimulus,
// configuration phases and the verdict. Depends on mcr_pkg, the block and circle_point_checker.
module tb_top
  import mcr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit   = 5000; // cycles with no word moving on either channel
  localparam int SettleCycles = 12;   // let a start or dropped step finish before a write
  localparam int TailCycles   = 16;   // one step's eight points plus margin

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                cmd_i      = CmdStart;
  logic [CoordW-1:0]   center_x_i = '0;
  logic [CoordW-1:0]   center_y_i = '0;
  logic [RadW-1:0]     radius_i   = '0;
  logic [ColorW-1:0]   color_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PixW-1:0]     pix_x_o;
  logic [PixW-1:0]     pix_y_o;
  logic                in_bounds_o;
  logic [AddrW-1:0]    byte_addr_o;
  logic [ColorW-1:0]   color_out_o;
  logic                last_o;

  int unsigned mismatches;
  int unsigned points_due;
  int unsigned points_checked;

  logic calm = 1'b0;       // high: neither side idles
  int   span_x = 640;      // visible columns of the current geometry
  int   span_y = 480;      // visible rows of the current geometry
  int   words_in = 0;      // every word accepted by the block
  int   planned = 0;       // starts and steps that do real work
  int   quiet = 0;

  midpoint_circle_rasterizer u_dut (.*);

  circle_point_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .cmd_i            (cmd_i),
    .center_x_i       (center_x_i),
    .center_y_i       (center_y_i),
    .radius_i         (radius_i),
    .color_i          (color_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pix_x_i          (pix_x_o),
    .pix_y_i          (pix_y_o),
    .in_bounds_i      (in_bounds_o),
    .byte_addr_i      (byte_addr_o),
    .color_out_i      (color_out_o),
    .last_i           (last_o),
    .mismatches_o     (mismatches),
    .points_due_o     (points_due),
    .points_checked_o (points_checked)
  );

  always #5 clk_i = ~clk_i;

  // Receiver back-pressure: stall at random about 30 percent of the time, never while calm.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 30);
  end

  // Watchdog: end the run if no word moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("Watchdog: no word moved for %0d cycles", QuietLimit);
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Offer one word and hold it until the block takes it. Random idle cycles
  // go in front, so gaps land at every point of the step sequence.
  task automatic push_word(logic cmd, logic [CoordW-1:0] cx, logic [CoordW-1:0] cy,
                           logic [RadW-1:0] rad, logic [ColorW-1:0] col);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    center_x_i <= cx;
    center_y_i <= cy;
    radius_i   <= rad;
    color_i    <= col;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_in++;
  endtask

  // Step words ignore their payload; fill it with noise anyway.
  task automatic step_circle();
    push_word(CmdStep, CoordW'($urandom), CoordW'($urandom), RadW'($urandom), $urandom);
  endtask

  // Stop sending and wait until every predicted point has come out, then
  // give the block time to finish a start or a dropped step.
  task automatic drain_points();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (points_due != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // Write all four registers; call only with the block drained.
  task automatic set_geometry(int w, int h, int bpp, int stride);
    int wv;
    int hv;
    write_reg(CfgImageWidth, CfgDataW'(w));
    write_reg(CfgImageHeight, CfgDataW'(h));
    write_reg(CfgBytesPerPix, CfgDataW'(bpp));
    write_reg(CfgRowStride, CfgDataW'(stride));
    cfg_we_i <= 1'b0;
    // Track the visible area the way the block clamps it, for centre placement.
    wv = w % 8192;
    hv = h % 8192;
    span_x = (wv == 0) ? 64 : ((wv > 4096) ? 4096 : wv);
    span_y = (hv == 0) ? 64 : ((hv > 4096) ? 4096 : hv);
  endtask

  // One random sequence: mostly a start followed by enough steps to close the
  // circle, sometimes cut short (the next start abandons it), sometimes one
  // step too many, and now and then a lone word with random content.
  task automatic random_circle();
    int   cx;
    int   cy;
    int   rad;
    int   steps;
    logic cmd;
    if ($urandom_range(99) < 12) begin
      cmd = 1'($urandom);
      push_word(cmd, CoordW'($urandom), CoordW'($urandom), RadW'($urandom), $urandom);
      if (cmd == CmdStart) planned++;
      return;
    end
    if ($urandom_range(3) == 0) begin
      cx = int'($urandom_range(16383)) - 8192;
      cy = int'($urandom_range(16383)) - 8192;
    end else begin
      cx = int'($urandom_range(span_x + 63)) - 32;
      cy = int'($urandom_range(span_y + 63)) - 32;
    end
    rad = ($urandom_range(9) == 0) ? int'($urandom_range(2047)) : int'($urandom_range(20));
    // Large circles would take up to 1448 steps: walk one to four columns only.
    steps = (rad > 64) ? int'($urandom_range(1, 4)) : rad * 707 / 1000 + 1;
    if ($urandom_range(99) < 15) steps = int'($urandom_range(1, steps));
    push_word(CmdStart, cx[CoordW-1:0], cy[CoordW-1:0], rad[RadW-1:0], $urandom);
    planned += 1 + steps;
    repeat (steps) step_circle();
    if ($urandom_range(9) == 0) step_circle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words on the reset geometry (640 x 480, 3 bytes, stride 1920).
    // Zero radius: eight points on the centre, then a step with nothing active.
    push_word(CmdStart, 14'd100, 14'd100, 11'd0, 32'h0123_4567);
    step_circle();
    step_circle();
    // Radius one at the far image corner: points straddle the right and bottom edges.
    push_word(CmdStart, 14'd639, 14'd479, 11'd1, 32'hFFFF_FFFF);
    step_circle();
    // Largest centre and radius, then abandoned by a start at the smallest centre.
    push_word(CmdStart, 14'h1FFF, 14'h1FFF, 11'd2047, 32'hFFFF_FFFF);
    step_circle();
    step_circle();
    push_word(CmdStart, 14'h2000, 14'h2000, 11'd2047, 32'h0000_0000);
    step_circle();
    step_circle();
    // Centre just off the top-left corner: negative coordinates are out of bounds.
    push_word(CmdStart, 14'h3FFF, 14'h3FFF, 11'd3, 32'hA5A5_5A5A);
    repeat (4) step_circle();
    // A full walk of a mid-sized circle well inside the image.
    push_word(CmdStart, 14'd320, 14'd240, 11'd10, 32'h00C0_FFEE);
    repeat (8) step_circle();

    // Random sequences over several geometries; drain before each change.
    for (int ph = 0; ph < 5; ph++) begin
      drain_points();
      case (ph)
        0: set_geometry(32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF); // masks, clamp, wrap
        1: set_geometry(0, 0, 0, 0);                             // nothing in bounds
        2: set_geometry(1, 1, 1, 1);                             // single pixel
        3: set_geometry(4096, 4096, 4, 16384);                   // top of range
        default: set_geometry(int'($urandom_range(1, 4096)), int'($urandom_range(1, 4096)),
                              int'($urandom_range(1, 4)), int'($urandom_range(1, 16384)));
      endcase
      calm = (ph == 3);
      planned = 0;
      while (planned < 22) random_circle();
    end
    calm = 1'b0;

    drain_points();
    repeat (TailCycles) @(posedge clk_i);
    $display("Covered %0d input words and %0d point words over six geometries,", words_in,
             points_checked);
    $display("with idling and back-pressure on both channels and one stall-free phase.");
    if (mismatches == 0 && points_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d points never seen", mismatches, points_due);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
